>>> hdl/rnp_pkg.sv
// ----------------------------------------------------------------------------
// rnp_pkg
// Shared types, constants and tone table for the RTTTL note parser.
// ----------------------------------------------------------------------------
`default_nettype none
package rnp_pkg;

  localparam int CharW = 8;
  localparam int FreqW = 21;
  localparam int DurW  = 19;
  localparam int WholeW = 18;
  localparam int DivW  = 18;

  localparam logic [17:0] WholeDividend = 18'd240000;
  localparam logic [15:0] TempoDefault  = 16'd120;
  localparam logic [15:0] DurDefault    = 16'd4;
  localparam logic [3:0]  OctDefault    = 4'd5;
  localparam logic [17:0] WholeDefault  = 18'd2000;

  // input transaction: one text byte
  typedef struct packed {
    logic [CharW-1:0] char_code;
    logic             end_of_text;
  } text_byte_t;

  // output transaction: one note item
  typedef struct packed {
    logic             note_valid;
    logic [FreqW-1:0] frequency_hz;
    logic [DurW-1:0]  duration_ms;
    logic             end_of_song;
    logic             format_error;
  } note_item_t;

  // controller commands to the datapath
  typedef struct packed {
    logic start_tempo;   // start whole = 240000 / tempo
    logic start_note;    // start ms = whole / duration
    logic load_result;   // build result item from quotient
  } rnp_cmd_t;

  // datapath status to the controller
  typedef struct packed {
    logic div_done;
  } rnp_status_t;

  // octave-4 tone for semitone index
  function automatic logic [8:0] tone_c4(input logic [3:0] idx);
    logic [8:0] t;
    case (idx)
      4'd0:  t = 9'd262;
      4'd1:  t = 9'd277;
      4'd2:  t = 9'd294;
      4'd3:  t = 9'd311;
      4'd4:  t = 9'd330;
      4'd5:  t = 9'd349;
      4'd6:  t = 9'd370;
      4'd7:  t = 9'd392;
      4'd8:  t = 9'd415;
      4'd9:  t = 9'd440;
      4'd10: t = 9'd466;
      default: t = 9'd494;
    endcase
    return t;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

endpackage
`default_nettype wire

>>> hdl/rnp_stream_if.sv
// ----------------------------------------------------------------------------
// rnp_stream_if
// Valid/ready channel carrying a generic payload.
// ----------------------------------------------------------------------------
`default_nettype none
interface rnp_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hdl/rnp_datapath.sv
// ----------------------------------------------------------------------------
// rnp_datapath
// Byte parser registers, shared restoring divider and result builder.
// ----------------------------------------------------------------------------
`default_nettype none
module rnp_datapath import rnp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        byte_en,    // accept one byte
  input  wire logic [7:0]  char_code,
  input  wire logic        last,
  input  wire rnp_cmd_t    cmd,
  output rnp_status_t      status,
  output logic             byte_emit,  // this byte yields a note
  output logic             byte_tempo, // this byte is the second colon
  output logic             res_valid,
  output logic [FreqW-1:0] res_freq,
  output logic [DurW-1:0]  res_dur,
  output logic             res_err
);

  typedef enum logic [1:0] {SEC_NAME, SEC_DEFS, SEC_NOTES} sec_t;
  typedef enum logic [2:0] {DT_START, DT_KEY, DT_SPACE, DT_SIGN, DT_DIGITS,
                            DT_IGNORE} dt_t;
  typedef enum logic [2:0] {NP_START, NP_DUR, NP_NAME, NP_SHARP, NP_DOT, NP_OCT,
                            NP_AFTER, NP_SKIP} np_t;

  sec_t        section;
  dt_t         dphase;
  logic [1:0]  dkey;
  logic [15:0] dacc;
  logic [15:0] ddur;
  logic [3:0]  doct;
  logic [15:0] tempo;
  logic [WholeW-1:0] whole;
  np_t         nphase;
  logic [15:0] nf_dur;
  logic [3:0]  nf_oct;
  logic [7:0]  nf_letter;
  logic        nf_sharp;
  logic        nf_dot;

  // latched per-byte status for the result
  logic pend_emit;
  logic pend_err;
  logic res_clear;

  sec_t        section_next;
  dt_t         dphase_next;
  logic [1:0]  dkey_next;
  logic [15:0] dacc_next;
  logic [15:0] ddur_next;
  logic [3:0]  doct_next;
  logic [15:0] tempo_next;
  np_t         nphase_next;
  logic [15:0] nf_dur_next;
  logic [3:0]  nf_oct_next;
  logic [7:0]  nf_letter_next;
  logic        nf_sharp_next;
  logic        nf_dot_next;
  logic        emit;

  logic [3:0]  cdig;
  logic [19:0] dacc_mul;
  logic [19:0] ndur_mul;
  logic [7:0]  oct_mul;
  logic [7:0]  cfold;
  logic        wr_def;
  logic [15:0] wr_val;

  assign cdig  = char_code[3:0];
  assign cfold = (char_code >= 8'h41 && char_code <= 8'h5a) ?
                 char_code + 8'h20 : char_code;
  assign dacc_mul = {1'b0, dacc, 3'b000} + {3'b000, dacc, 1'b0} + {16'd0, cdig};
  assign ndur_mul = {1'b0, nf_dur, 3'b000} + {3'b000, nf_dur, 1'b0} + {16'd0, cdig};
  assign oct_mul  = {1'b0, nf_oct, 3'b000} + {3'b000, nf_oct, 1'b0} + {4'd0, cdig};

  // byte parsing
  always_comb begin
    section_next   = section;
    dphase_next    = dphase;
    dkey_next      = dkey;
    dacc_next      = dacc;
    ddur_next      = ddur;
    doct_next      = doct;
    tempo_next     = tempo;
    nphase_next    = nphase;
    nf_dur_next    = nf_dur;
    nf_oct_next    = nf_oct;
    nf_letter_next = nf_letter;
    nf_sharp_next  = nf_sharp;
    nf_dot_next    = nf_dot;
    emit           = 1'b0;
    byte_tempo     = 1'b0;
    wr_def         = 1'b0;
    wr_val         = 16'd0;
    case (section)
      SEC_NAME: begin
        if (char_code == 8'h3a) section_next = SEC_DEFS;
      end
      SEC_DEFS: begin
        if (char_code == 8'h3a) begin
          if (ddur == 16'd0) ddur_next = DurDefault;
          if (tempo == 16'd0) tempo_next = TempoDefault;
          section_next = SEC_NOTES;
          nphase_next  = NP_START;
          byte_tempo   = 1'b1;
        end else if (char_code == 8'h2c) begin
          dphase_next = DT_START;
        end else begin
          case (dphase)
            DT_START: begin
              if (char_code == 8'h64 || char_code == 8'h6f || char_code == 8'h62) begin
                dkey_next = (char_code == 8'h64) ? 2'd0 :
                            (char_code == 8'h6f) ? 2'd1 : 2'd2;
                dphase_next = DT_KEY;
              end else dphase_next = DT_IGNORE;
            end
            DT_KEY: begin
              if (char_code == 8'h3d) begin
                dacc_next = 16'd0; wr_def = 1'b1; wr_val = 16'd0;
                dphase_next = DT_SPACE;
              end else dphase_next = DT_IGNORE;
            end
            DT_SPACE, DT_SIGN: begin
              if (dphase == DT_SPACE && (char_code == 8'h20 ||
                  (char_code >= 8'd9 && char_code <= 8'd13))) begin
                dphase_next = dphase;
              end else if (dphase == DT_SPACE && char_code == 8'h2b) begin
                dphase_next = DT_SIGN;
              end else if (is_digit(char_code)) begin
                dacc_next = {12'd0, cdig}; wr_def = 1'b1; wr_val = {12'd0, cdig};
                dphase_next = DT_DIGITS;
              end else dphase_next = DT_IGNORE;
            end
            DT_DIGITS: begin
              if (is_digit(char_code)) begin
                wr_val = (dacc_mul > 20'd65535) ? 16'hffff : dacc_mul[15:0];
                dacc_next = wr_val; wr_def = 1'b1;
              end else dphase_next = DT_IGNORE;
            end
            default: ;
          endcase
          if (wr_def) begin
            case (dkey)
              2'd0: ddur_next = wr_val;
              2'd1: doct_next = (wr_val > 16'd15) ? 4'd15 : wr_val[3:0];
              default: tempo_next = wr_val;
            endcase
          end
        end
      end
      default: begin
        // note section
        if (nphase == NP_START) begin
          if (char_code != 8'h20 && char_code != 8'h2c) begin
            nf_dur_next = 16'd0; nf_oct_next = doct;
            nf_sharp_next = 1'b0; nf_dot_next = 1'b0;
            if (is_digit(char_code)) begin
              nf_dur_next = {12'd0, cdig}; nphase_next = NP_DUR;
            end else begin
              nf_letter_next = cfold; nphase_next = NP_NAME;
            end
          end
        end else if (nphase == NP_DUR) begin
          if (is_digit(char_code))
            nf_dur_next = (ndur_mul > 20'd65535) ? 16'hffff : ndur_mul[15:0];
          else begin
            nf_letter_next = cfold; nphase_next = NP_NAME;
          end
        end else if (nphase == NP_NAME && char_code == 8'h23) begin
          nf_sharp_next = 1'b1; nphase_next = NP_SHARP;
        end else if ((nphase == NP_NAME || nphase == NP_SHARP) &&
                     char_code == 8'h2e) begin
          nf_dot_next = 1'b1; nphase_next = NP_DOT;
        end else if ((nphase == NP_NAME || nphase == NP_SHARP || nphase == NP_DOT)
                     && is_digit(char_code)) begin
          nf_oct_next = cdig; nphase_next = NP_OCT;
        end else if (nphase == NP_OCT && is_digit(char_code)) begin
          nf_oct_next = (oct_mul > 8'd15) ? 4'd15 : oct_mul[3:0];
        end else if (nphase != NP_SKIP && char_code == 8'h2e) begin
          nf_dot_next = 1'b1; nphase_next = NP_SKIP;
        end else begin
          nphase_next = NP_SKIP;
          if (char_code == 8'h2c) begin
            nphase_next = NP_START; emit = 1'b1;
          end
        end
      end
    endcase
    if (!emit && last && section_next == SEC_NOTES && nphase_next >= NP_NAME)
      emit = 1'b1;
  end

  assign byte_emit = emit;

  // shared restoring divider: one quotient bit per cycle
  logic [DivW-1:0] dv_rem;
  logic [DivW-1:0] dv_quo;
  logic [15:0]     dv_den;
  logic [4:0]      dv_cnt;
  logic            dv_busy;
  logic            dv_is_tempo;
  logic [DivW:0]   dv_trial;
  logic [DivW-1:0] dv_rem_sh;
  logic [15:0]     note_den;

  assign note_den  = (nf_dur != 16'd0) ? nf_dur : ((ddur != 16'd0) ? ddur : DurDefault);
  assign dv_rem_sh = {dv_rem[DivW-2:0], dv_quo[DivW-1]};
  assign dv_trial  = {1'b0, dv_rem_sh} - {3'd0, dv_den};
  assign status.div_done = dv_busy && (dv_cnt == 5'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_busy <= 1'b0;
      dv_cnt  <= 5'd0;
    end else if (cmd.start_tempo || cmd.start_note) begin
      dv_busy     <= 1'b1;
      dv_cnt      <= 5'(DivW);
      dv_is_tempo <= cmd.start_tempo;
      dv_rem      <= '0;
      dv_quo      <= cmd.start_tempo ? WholeDividend : whole;
      // tempo after the zero-means-default rule of the second colon
      dv_den      <= cmd.start_tempo ? tempo_next : note_den;
    end else if (dv_busy && dv_cnt != 5'd0) begin
      dv_cnt <= dv_cnt - 5'd1;
      if (!dv_trial[DivW]) begin
        dv_rem <= dv_trial[DivW-1:0];
        dv_quo <= {dv_quo[DivW-2:0], 1'b1};
      end else begin
        dv_rem <= dv_rem_sh;
        dv_quo <= {dv_quo[DivW-2:0], 1'b0};
      end
    end else if (status.div_done) begin
      dv_busy <= 1'b0;
    end
  end

  // tone lookup
  logic [3:0]  t_idx;
  logic        t_ok;
  logic [4:0]  t_oct;
  logic [3:0]  t_i2;
  logic [8:0]  t_base;
  logic [FreqW-1:0] t_hz;
  always_comb begin
    t_ok = 1'b1;
    case (nf_letter)
      8'h63: t_idx = 4'd0;
      8'h64: t_idx = 4'd2;
      8'h65: t_idx = 4'd4;
      8'h66: t_idx = 4'd5;
      8'h67: t_idx = 4'd7;
      8'h61: t_idx = 4'd9;
      8'h62: t_idx = 4'd11;
      default: begin t_idx = 4'd0; t_ok = 1'b0; end
    endcase
    t_i2  = t_idx + {3'd0, nf_sharp};
    t_oct = {1'b0, nf_oct};
    if (t_i2 >= 4'd12) begin
      t_i2 = t_i2 - 4'd12; t_oct = t_oct + 5'd1;
    end
    t_base = tone_c4(t_i2);
    if (t_oct >= 5'd4)
      t_hz = FreqW'({12'd0, t_base} << (t_oct - 5'd4));
    else
      t_hz = FreqW'(({12'd0, t_base} + (FreqW'(1) << (5'd4 - t_oct)) - FreqW'(1))
             >> (5'd4 - t_oct));
    if (!t_ok) t_hz = '0;
  end

  logic [DurW-1:0] ms_q;
  logic [DurW-1:0] ms_dot;
  assign ms_q   = {1'b0, dv_quo};
  assign ms_dot = nf_dot ? ms_q + (ms_q >> 1) : ms_q;

  // state registers
  always_ff @(posedge clk) begin
    if (rst || (byte_en && last && !emit) || (cmd.load_result && res_clear)) begin
      section <= SEC_NAME; dphase <= DT_START; dkey <= 2'd0; dacc <= 16'd0;
      ddur <= DurDefault; doct <= OctDefault; tempo <= TempoDefault;
      whole <= WholeDefault; nphase <= NP_START;
      nf_dur <= 16'd0; nf_oct <= 4'd0; nf_letter <= 8'd0;
      nf_sharp <= 1'b0; nf_dot <= 1'b0;
    end else begin
      if (byte_en) begin
        section <= section_next; dphase <= dphase_next; dkey <= dkey_next;
        dacc <= dacc_next; ddur <= ddur_next; doct <= doct_next;
        tempo <= tempo_next; nphase <= nphase_next;
        nf_dur <= nf_dur_next; nf_oct <= nf_oct_next;
        nf_letter <= nf_letter_next; nf_sharp <= nf_sharp_next;
        nf_dot <= nf_dot_next;
      end
      if (status.div_done && dv_is_tempo) whole <= dv_quo;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (byte_en) begin
      pend_emit <= emit;
      pend_err  <= last && (section_next != SEC_NOTES);
      res_clear <= last;
    end
    if (byte_en && !emit) begin
      res_valid <= 1'b0; res_freq <= '0; res_dur <= '0;
      res_err   <= last && (section_next != SEC_NOTES);
    end else if (cmd.load_result) begin
      res_valid <= pend_emit;
      res_freq  <= t_hz;
      res_dur   <= (ms_dot == '0) ? DurW'(1) : ms_dot;
      res_err   <= pend_err;
    end
  end

endmodule
`default_nettype wire

>>> hdl/rnp_ctrl.sv
// ----------------------------------------------------------------------------
// rnp_ctrl
// Sequencer: takes a byte, runs the divider when needed, hands out results.
// ----------------------------------------------------------------------------
`default_nettype none
module rnp_ctrl import rnp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_last,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_last,
  input  wire logic        byte_emit,
  input  wire logic        byte_tempo,
  input  wire rnp_status_t status,
  output rnp_cmd_t         cmd,
  output logic             byte_en
);

  typedef enum logic [2:0] {S_IDLE, S_TEMPO, S_NOTE_GO, S_NOTE, S_LOAD,
                            S_OUT} state_t;
  state_t state;
  logic   last_q;

  assign in_ready  = (state == S_IDLE);
  assign byte_en   = in_valid && in_ready;
  assign out_valid = (state == S_OUT);
  assign out_last  = last_q;

  // a second colon that ends the text needs no divide: all state resets
  always_comb begin
    cmd = '0;
    cmd.start_tempo = (state == S_IDLE) && byte_en && byte_tempo && !in_last;
    cmd.start_note  = (state == S_NOTE_GO);
    cmd.load_result = (state == S_LOAD);
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      last_q <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (byte_en) begin
            last_q <= in_last;
            if (byte_tempo && !in_last) state <= S_TEMPO;
            else if (byte_emit) state <= S_NOTE_GO;
            else if (in_last) state <= S_OUT;
          end
        end
        S_TEMPO: begin
          if (status.div_done) state <= last_q ? S_OUT : S_IDLE;
        end
        S_NOTE_GO: state <= S_NOTE;
        S_NOTE: begin
          if (status.div_done) state <= S_LOAD;
        end
        S_LOAD: state <= S_OUT;
        S_OUT: begin
          if (out_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready) else $error("accept while busy");
  a_load_after_div: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOAD) |-> $past(status.div_done)) else $error("load without divide");
  a_out_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");

endmodule
`default_nettype wire

>>> hdl/rtttl_note_parser_core.sv
// ----------------------------------------------------------------------------
// rtttl_note_parser_core
// RTTTL text parser producing note frequency and duration items.
// ----------------------------------------------------------------------------
// Usage: text bytes enter on in_ch (char_code, end_of_text); result items
// leave on out_ch. A byte that ends a note (comma, or final byte after a
// letter) or the final byte of the text yields exactly one result; other
// bytes yield none.
// The second colon, unless it ends the text, starts an 18-step restoring
// divide for the whole-note time; the next byte is taken once it is done.
// A note end runs the same divider for whole/dur, then builds the result
// in the load state before out_valid rises.
// One byte is in work at a time; in_ready is low from acceptance until the
// result is taken. When the receiver stalls, the result holds and no new
// byte is accepted. Synchronous reset returns to the name section with
// defaults d=4, o=5, b=120; the final byte also returns all state to that.
// ----------------------------------------------------------------------------
`default_nettype none
module rtttl_note_parser_core import rnp_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  rnp_stream_if.sink   in_ch,
  rnp_stream_if.source out_ch
);

  rnp_cmd_t    cmd;
  rnp_status_t status;
  logic byte_en, byte_emit, byte_tempo, last_q;
  logic res_valid, res_err;
  logic [FreqW-1:0] res_freq;
  logic [DurW-1:0]  res_dur;

  rnp_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_last(in_ch.data.end_of_text),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_last(last_q),
    .byte_emit(byte_emit), .byte_tempo(byte_tempo), .status(status),
    .cmd(cmd), .byte_en(byte_en)
  );

  rnp_datapath u_dp (
    .clk(clk), .rst(rst), .byte_en(byte_en),
    .char_code(in_ch.data.char_code), .last(in_ch.data.end_of_text),
    .cmd(cmd), .status(status), .byte_emit(byte_emit), .byte_tempo(byte_tempo),
    .res_valid(res_valid), .res_freq(res_freq), .res_dur(res_dur), .res_err(res_err)
  );

  assign out_ch.data.note_valid   = res_valid;
  assign out_ch.data.frequency_hz = res_freq;
  assign out_ch.data.duration_ms  = res_dur;
  assign out_ch.data.end_of_song  = last_q;
  assign out_ch.data.format_error = res_err;

endmodule
`default_nettype wire

>>> tb/tb_rtttl_note_parser_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rtttl_note_parser_core
// Self-checking testbench for the RTTTL note parser core.
// Text bytes are sent through the input channel while a behavioral note model
// predicts each note item. A checker compares every output transaction field
// by field. Short directed texts cover the edge cases, random ringtones and
// byte noise follow, with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_rtttl_note_parser_core;
  import rnp_pkg::*;

  typedef enum logic [1:0] {SecName, SecDefaults, SecNotes} section_t;
  typedef enum logic [2:0] {
    DtStart, DtKey, DtSpace, DtSign, DtDigits, DtIgnore
  } dflt_phase_t;
  typedef enum logic [2:0] {
    NpStart, NpDur, NpName, NpSharp, NpDot, NpOct, NpAfterOct, NpSkip
  } note_phase_t;
  typedef enum logic [1:0] {KeyDur, KeyOct, KeyTempo} dflt_key_t;

  logic clk;
  logic rst;

  rnp_stream_if #(.payload_t(text_byte_t)) in_if ();
  rnp_stream_if #(.payload_t(note_item_t)) out_if ();

  rtttl_note_parser_core dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_if.sink),
    .out_ch (out_if.source)
  );

  // clock and limit
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #8ms;
    $display("tb_rtttl_note_parser_core: done, errors");
    $finish;
  end

  // parser model state
  section_t     m_section;
  dflt_phase_t  m_dphase;
  dflt_key_t    m_key;
  logic [15:0]  m_acc;
  logic [15:0]  m_dflt_dur;
  logic [3:0]   m_dflt_oct;
  logic [15:0]  m_tempo;
  logic [17:0]  m_whole;
  note_phase_t  m_nphase;
  logic [15:0]  m_dur;
  logic [3:0]   m_oct;
  logic [7:0]   m_letter;
  logic         m_sharp;
  logic         m_dot;

  note_item_t   expected_notes[$];
  int           err_cnt = 0;

  function automatic void parser_reset();
    m_section  = SecName;
    m_dphase   = DtStart;
    m_key      = KeyDur;
    m_acc      = '0;
    m_dflt_dur = 16'd4;
    m_dflt_oct = 4'd5;
    m_tempo    = 16'd120;
    m_whole    = 18'd2000;
    m_nphase   = NpStart;
    m_dur      = '0;
    m_oct      = '0;
    m_letter   = '0;
    m_sharp    = 1'b0;
    m_dot      = 1'b0;
  endfunction

  function automatic bit digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [15:0] sat16(input int unsigned v);
    return (v > 65535) ? 16'hffff : v[15:0];
  endfunction

  function automatic logic [3:0] sat_oct(input int unsigned v);
    return (v > 15) ? 4'd15 : v[3:0];
  endfunction

  function automatic logic [20:0] tone_hz(input logic [7:0] letter, input logic sharp,
                                          input logic [3:0] oct4);
    int unsigned idx, hz, oct;
    case (letter)
      "c": idx = 0;
      "d": idx = 2;
      "e": idx = 4;
      "f": idx = 5;
      "g": idx = 7;
      "a": idx = 9;
      "b": idx = 11;
      default: return '0;
    endcase
    oct = oct4;
    if (sharp) idx++;
    if (idx >= 12) begin
      idx -= 12;
      oct++;
    end
    case (idx)
      0: hz = 262;  1: hz = 277;  2: hz = 294;  3: hz = 311;
      4: hz = 330;  5: hz = 349;  6: hz = 370;  7: hz = 392;
      8: hz = 415;  9: hz = 440;  10: hz = 466; default: hz = 494;
    endcase
    if (oct > 4) hz = hz << (oct - 4);
    while (oct < 4) begin
      hz = (hz + 1) / 2;
      oct++;
    end
    return hz[20:0];
  endfunction

  function automatic void store_default();
    case (m_key)
      KeyDur:  m_dflt_dur = m_acc;
      KeyOct:  m_dflt_oct = sat_oct(m_acc);
      default: m_tempo = m_acc;
    endcase
  endfunction

  // one byte of the defaults section
  function automatic void defaults_byte(input logic [7:0] c);
    if (c == ",") begin
      m_dphase = DtStart;
      return;
    end
    case (m_dphase)
      DtStart: begin
        if (c == "d" || c == "o" || c == "b") begin
          m_key = (c == "d") ? KeyDur : (c == "o") ? KeyOct : KeyTempo;
          m_dphase = DtKey;
        end else begin
          m_dphase = DtIgnore;
        end
      end
      DtKey: begin
        if (c == "=") begin
          m_acc = '0;
          store_default();
          m_dphase = DtSpace;
        end else begin
          m_dphase = DtIgnore;
        end
      end
      DtSpace, DtSign: begin
        if (m_dphase == DtSpace && (c == " " || (c >= 9 && c <= 13))) begin
        end else if (m_dphase == DtSpace && c == "+") begin
          m_dphase = DtSign;
        end else if (digit(c)) begin
          m_acc = c - "0";
          store_default();
          m_dphase = DtDigits;
        end else begin
          m_dphase = DtIgnore;
        end
      end
      DtDigits: begin
        if (digit(c)) begin
          m_acc = sat16(m_acc * 10 + (c - "0"));
          store_default();
        end else begin
          m_dphase = DtIgnore;
        end
      end
      default: ;
    endcase
  endfunction

  // one byte of the notes section, 1 when a comma closes a note
  function automatic bit notes_byte(input logic [7:0] c);
    note_phase_t st;
    st = m_nphase;
    if (st == NpStart) begin
      if (c == " " || c == ",") return 1'b0;
      m_dur = '0;
      m_oct = m_dflt_oct;
      m_sharp = 1'b0;
      m_dot = 1'b0;
      if (digit(c)) begin
        m_dur = c - "0";
        m_nphase = NpDur;
      end else begin
        m_letter = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
        m_nphase = NpName;
      end
      return 1'b0;
    end
    if (st == NpDur) begin
      if (digit(c)) begin
        m_dur = sat16(m_dur * 10 + (c - "0"));
      end else begin
        m_letter = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
        m_nphase = NpName;
      end
      return 1'b0;
    end
    if (st == NpName) begin
      if (c == "#") begin
        m_sharp = 1'b1;
        m_nphase = NpSharp;
        return 1'b0;
      end
      st = NpSharp;
    end
    if (st == NpSharp) begin
      if (c == ".") begin
        m_dot = 1'b1;
        m_nphase = NpDot;
        return 1'b0;
      end
      st = NpDot;
    end
    if (st == NpDot) begin
      if (digit(c)) begin
        m_oct = c - "0";
        m_nphase = NpOct;
        return 1'b0;
      end
      st = NpAfterOct;
    end
    if (st == NpOct) begin
      if (digit(c)) begin
        m_oct = sat_oct(m_oct * 10 + (c - "0"));
        return 1'b0;
      end
      st = NpAfterOct;
    end
    if (st == NpAfterOct && c == ".") begin
      m_dot = 1'b1;
      m_nphase = NpSkip;
      return 1'b0;
    end
    m_nphase = NpSkip;
    if (c == ",") begin
      m_nphase = NpStart;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // advance the model by one accepted byte, queue any note item
  function automatic void predict_note(input text_byte_t b);
    bit emit;
    int unsigned d, ms;
    note_item_t r;
    emit = 1'b0;
    case (m_section)
      SecName: if (b.char_code == ":") m_section = SecDefaults;
      SecDefaults: begin
        if (b.char_code == ":") begin
          if (m_dflt_dur == 0) m_dflt_dur = 16'd4;
          if (m_tempo == 0) m_tempo = 16'd120;
          m_whole = 240000 / m_tempo;
          m_section = SecNotes;
          m_nphase = NpStart;
        end else begin
          defaults_byte(b.char_code);
        end
      end
      default: emit = notes_byte(b.char_code);
    endcase
    if (!emit && b.end_of_text && m_section == SecNotes && m_nphase >= NpName)
      emit = 1'b1;
    if (!emit && !b.end_of_text) return;
    r = '0;
    if (emit) begin
      d = (m_dur != 0) ? m_dur : m_dflt_dur;
      if (d == 0) d = 4;
      ms = m_whole / d;
      if (m_dot) ms += ms / 2;
      if (ms == 0) ms = 1;
      r.note_valid = 1'b1;
      r.duration_ms = ms[18:0];
      r.frequency_hz = (m_letter == "p") ? '0 : tone_hz(m_letter, m_sharp, m_oct);
    end
    r.end_of_song = b.end_of_text;
    r.format_error = b.end_of_text && m_section != SecNotes;
    expected_notes.push_back(r);
    if (b.end_of_text) parser_reset();
  endfunction

  // sender: bursts with random gaps
  bit tx_idle_on = 1'b1;
  int burst_left = 0;

  task automatic send_byte(input logic [7:0] c, input bit last);
    int gap;
    text_byte_t b;
    if (tx_idle_on && burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    b.char_code = c;
    b.end_of_text = last;
    in_if.valid <= 1'b1;
    in_if.data <= b;
    do @(posedge clk); while (!in_if.ready);
    predict_note(b);
  endtask

  task automatic send_text(input string s, input bit close);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i], close && (i == s.len() - 1));
  endtask

  task automatic sender_idle();
    in_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  // receiver: stall pattern plus requested hold-off
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int rx_cycle = 0;
  int rx_mode = 0;

  always @(posedge clk) begin
    if (!rst && out_if.valid && out_if.ready) check_note(out_if.data);
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = 600;
    end
    rx_cycle++;
    if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 3);
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= ($urandom_range(0, 3) != 0);
        2: out_if.ready <= rx_cycle[0];
        default: out_if.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  task automatic check_note(input note_item_t got);
    note_item_t exp_n;
    if (expected_notes.size() == 0) begin
      $display("%0t: unexpected transaction %p", $realtime, got);
      err_cnt++;
      return;
    end
    exp_n = expected_notes.pop_front();
    if (got.note_valid !== exp_n.note_valid) begin
      $display("%0t: note_valid exp %0d got %0d", $realtime, exp_n.note_valid,
               got.note_valid);
      err_cnt++;
    end
    if (got.frequency_hz !== exp_n.frequency_hz) begin
      $display("%0t: frequency_hz exp %0d got %0d", $realtime, exp_n.frequency_hz,
               got.frequency_hz);
      err_cnt++;
    end
    if (got.duration_ms !== exp_n.duration_ms) begin
      $display("%0t: duration_ms exp %0d got %0d", $realtime, exp_n.duration_ms,
               got.duration_ms);
      err_cnt++;
    end
    if (got.end_of_song !== exp_n.end_of_song) begin
      $display("%0t: end_of_song exp %0d got %0d", $realtime, exp_n.end_of_song,
               got.end_of_song);
      err_cnt++;
    end
    if (got.format_error !== exp_n.format_error) begin
      $display("%0t: format_error exp %0d got %0d", $realtime, exp_n.format_error,
               got.format_error);
      err_cnt++;
    end
  endtask

  // random text pieces
  function automatic string rand_digits(input int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = {s, string'(8'("0" + $urandom_range(0, 9)))};
    return s;
  endfunction

  function automatic string rand_defaults();
    string s, keys;
    int n;
    keys = "dob";
    s = "";
    n = $urandom_range(0, 4);
    for (int i = 0; i < n; i++) begin
      if (i > 0) s = {s, ","};
      case ($urandom_range(0, 9))
        0: s = {s, "x=3"};
        1: s = {s, string'(keys[$urandom_range(0, 2)]), "=-5"};
        2: s = {s, string'(keys[$urandom_range(0, 2)]), "= +", rand_digits(2)};
        3: s = {s, string'(keys[$urandom_range(0, 2)]), "="};
        4: s = {s, "b=", rand_digits($urandom_range(1, 6))};
        default: s = {s, string'(keys[$urandom_range(0, 2)]), "=",
                      rand_digits($urandom_range(1, 3))};
      endcase
    end
    return s;
  endfunction

  function automatic string rand_note();
    string s, letters;
    letters = "cdefgabpCDEFGABPhz ";
    s = "";
    case ($urandom_range(0, 5))
      0: s = {s, rand_digits($urandom_range(1, 6))};
      1, 2: s = {s, "8"};
      3: s = {s, "16"};
      default: ;
    endcase
    s = {s, string'(letters[$urandom_range(0, letters.len() - 1)])};
    if ($urandom_range(0, 2) == 0) s = {s, "#"};
    if ($urandom_range(0, 3) == 0) s = {s, "."};
    if ($urandom_range(0, 1)) s = {s, rand_digits($urandom_range(1, 2))};
    if ($urandom_range(0, 4) == 0) s = {s, "."};
    if ($urandom_range(0, 9) == 0) s = {s, "q"};
    return s;
  endfunction

  // random ringtone, rarely malformed
  task automatic send_random_song(output int nbytes);
    string s;
    int n;
    s = {"tune", ":", rand_defaults()};
    if ($urandom_range(0, 9) != 0) begin
      s = {s, ":"};
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) begin
        s = {s, rand_note()};
        if (i < n - 1 || $urandom_range(0, 1)) begin
          if ($urandom_range(0, 3) == 0) s = {s, ", "};
          else s = {s, ","};
        end
      end
    end
    nbytes = s.len();
    send_text(s, 1'b1);
  endtask

  task automatic wait_drained();
    while (expected_notes.size() != 0) @(posedge clk);
  endtask

  // test cases
  task automatic test_directed_extremes();
    send_text("x:d=1,o=99,b=1:b#.,", 1'b0);
    send_text("32p", 1'b1);
    send_text(":d=0,b=0:c0,65535c#,99999999a", 1'b1);
  endtask

  task automatic test_missing_colon();
    send_text("name", 1'b1);
    send_text("n:d=8", 1'b1);
    send_byte(":", 1'b1);
  endtask

  task automatic test_odd_tokens();
    send_text("a:dd=3, o= +7,b=-9,o=+:4", 1'b1);
    send_text("::,  ,:", 1'b1);
  endtask

  task automatic test_backpressure();
    hold_req++;
    send_text("p:b=200:c,d,e,f,g,a,b", 1'b1);
    sender_idle();
    wait_drained();
  endtask

  task automatic test_random_songs(input int budget);
    int sent, nb;
    sent = 0;
    while (sent < budget) begin
      tx_idle_on = ($urandom_range(0, 4) != 0);
      send_random_song(nb);
      sent += nb;
    end
    tx_idle_on = 1'b1;
  endtask

  task automatic test_byte_noise(input int count);
    logic [7:0] c;
    string noise_set;
    noise_set = ":,#.0123456789dob=";
    for (int i = 0; i < count; i++) begin
      c = ($urandom_range(0, 2) == 0) ? noise_set[$urandom_range(0, 17)]
                                      : 8'($urandom_range(0, 255));
      send_byte(c, ($urandom_range(0, 29) == 0) || i == count - 1);
    end
  endtask

  // sequence
  initial begin
    rst = 1'b1;
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    parser_reset();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_extremes();
    test_missing_colon();
    test_odd_tokens();
    test_backpressure();
    test_random_songs(1050);
    test_byte_noise(200);
    sender_idle();
    wait_drained();
    repeat (60) @(posedge clk);
    if (err_cnt == 0 && expected_notes.size() == 0) begin
      $display("tb_rtttl_note_parser_core: done, clean");
    end else begin
      $display("tb_rtttl_note_parser_core: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
